// ===== design/stochastic_kdj_oscillator_macros.svh =====
// Assertion macros for the stochastic KDJ oscillator checker.
// No dependencies.
`ifndef STOCHASTIC_KDJ_OSCILLATOR_MACROS_SVH
`define STOCHASTIC_KDJ_OSCILLATOR_MACROS_SVH
// implication checked every clock outside reset
`define KDJ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define KDJ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/kdj_pkg.sv =====
// Package for the stochastic KDJ oscillator: widths, defaults, config indexes.
// No dependencies.
`timescale 1ns / 1ps
package kdj_pkg;
    localparam int WINDOW_MAX_DEF    = 64;
    localparam int PRICE_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_IDX_BITS      = 2;
    localparam int CFG_DATA_BITS     = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KSMTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DSMTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLAG   = 2'd3;
    localparam logic [1:0] FLAG_UP   = 2'b01;
    localparam logic [1:0] FLAG_DOWN = 2'b11;
    localparam logic [1:0] FLAG_NONE = 2'b00;
endpackage

// ===== design/stochastic_kdj_oscillator.sv =====
// KDJ stochastic oscillator top level: ring store, window scan, sequencer.
// Depends on kdj_pkg and kdj_divider.
//
// channel  dir  tdata fields (low bit up)                      tuser
// s_axis   in   high_price, low_price, close_price             restart
// m_axis   out  rsv, k_value, d_value, j_value, limit_flag     -
// cfg      in   window_length, k/d_smoothing, initial_limit_flag
//
// An item is scanned over count = min(bars in series, window_length) ring entries,
// then takes up to three divides (RSV, K, D) in the shared divider, NB being
// PRICE_BITS+FRACTION_BITS+7 quotient bits; the divider yields one bit per cycle.
// A zero-range window skips the RSV divide, a series' first bar the K and D divides.
// Reset is synchronous, active low; ring contents are not cleared.
// A result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
module stochastic_kdj_oscillator #(
    parameter int WINDOW_MAX    = kdj_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS    = kdj_pkg::PRICE_BITS_DEF,
    parameter int FRACTION_BITS = kdj_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // high_price, low_price, close_price, zero fill
    input  logic [((3*PRICE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // restart
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // rsv, k_value, d_value, j_value, limit_flag, zero fill
    output logic [((4*FRACTION_BITS+40)/8)*8-1:0]  m_axis_tdata,
    input  logic                                   i_cfg_we,
    input  logic [kdj_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [kdj_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import kdj_pkg::*;

    localparam int PB   = PRICE_BITS;
    localparam int VB   = FRACTION_BITS + 7;
    localparam int JB   = FRACTION_BITS + 10;
    localparam int AB   = $clog2(WINDOW_MAX);
    localparam int CB   = $clog2(WINDOW_MAX + 1);
    localparam int NB   = PB + 7 + FRACTION_BITS;
    localparam int DB   = PB;
    localparam int ODW  = ((4*FRACTION_BITS+40)/8)*8;
    localparam int OFB  = 3*VB + JB + 2;
    localparam logic [VB-1:0] FULL = VB'(100) << FRACTION_BITS;
    localparam logic [VB-1:0] HALF = VB'(50) << FRACTION_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRE  = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_RSV  = 4'd3;
    localparam logic [3:0] S_RDIV = 4'd4;
    localparam logic [3:0] S_SMK  = 4'd5;
    localparam logic [3:0] S_KDIV = 4'd6;
    localparam logic [3:0] S_SMD  = 4'd7;
    localparam logic [3:0] S_DDIV = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [PB-1:0] r_hring [WINDOW_MAX];
    logic [PB-1:0] r_lring [WINDOW_MAX];

    logic [6:0] r_win;
    logic [7:0] r_m1, r_m2;
    logic [1:0] r_iflag;
    logic [3:0] r_st;
    logic [AB-1:0] r_ptr, r_idx;
    logic [CB-1:0] r_seen, r_cnt;
    logic [PB-1:0] r_h, r_l, r_c, r_hi, r_lo, r_ph, r_pl, r_rdh, r_rdl, r_cd;
    logic          r_rdv, r_first;
    logic [VB-1:0] r_prsv, r_rsv, r_k, r_d;
    logic [1:0]    r_flag;
    logic          r_neg;
    logic          r_ovalid;
    logic [OFB-1:0] r_odata;

    logic                w_dstart, w_ddone;
    logic [NB-1:0]       w_dnum, w_dq;
    logic [DB-1:0]       w_dden;
    logic [CB-1:0]       w_winc;
    logic [VB:0]         w_diff, w_dmag;
    logic [7:0]          w_m1, w_m2;
    logic [PB-1:0]       w_cc;
    logic [NB-1:0]       w_x, w_rsvnum;
    logic [VB+1:0]       w_k3, w_d2;
    logic [JB-1:0]       w_j;
    logic                w_oload;

    kdj_divider #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quot(w_dq)
    );

    always_comb begin
        if (r_win == 7'd0) w_winc = CB'(1);
        else if (32'(r_win) > WINDOW_MAX) w_winc = CB'(WINDOW_MAX);
        else w_winc = CB'(r_win);
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = ODW'(r_odata);
    assign w_oload       = (r_st == S_OUT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 7'd9; r_m1 <= 8'd3; r_m2 <= 8'd3; r_iflag <= FLAG_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW: r_win   <= i_cfg_data[6:0];
                CFG_KSMTH:  r_m1    <= i_cfg_data;
                CFG_DSMTH:  r_m2    <= i_cfg_data;
                CFG_FLAG:   r_iflag <= (i_cfg_data[1:0] == 2'b10) ? FLAG_NONE
                                                                  : i_cfg_data[1:0];
                default:    r_win   <= r_win;
            endcase
        end
    end

    // ring memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_st == S_PRE) begin
            r_hring[r_ptr] <= r_h;
            r_lring[r_ptr] <= r_l;
        end
        r_rdh <= r_hring[r_idx];
        r_rdl <= r_lring[r_idx];
    end

    // divider operand select
    assign w_m1     = (r_m1 == 8'd0) ? 8'd1 : r_m1;
    assign w_m2     = (r_m2 == 8'd0) ? 8'd1 : r_m2;
    assign w_cc     = (r_c < r_lo) ? r_lo : ((r_c > r_hi) ? r_hi : r_c);
    assign w_x      = NB'(r_cd);
    assign w_rsvnum = ((w_x << 6) + (w_x << 5) + (w_x << 2)) << FRACTION_BITS;

    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = '0;
        w_dden   = '0;
        w_diff   = '0;
        unique case (r_st)
            S_RSV: begin
                w_dstart = r_hi > r_lo;
                w_dnum   = w_rsvnum;
                w_dden   = r_hi - r_lo;
            end
            S_SMK: begin
                w_diff   = {1'b0, r_rsv} - {1'b0, r_k};
                w_dstart = !r_first;
                w_dden   = DB'(w_m1);
            end
            S_SMD: begin
                w_diff   = {1'b0, r_k} - {1'b0, r_d};
                w_dstart = 1'b1;
                w_dden   = DB'(w_m2);
            end
            default: w_dstart = 1'b0;
        endcase
        w_dmag = w_diff[VB] ? ((~w_diff) + 1'b1) : w_diff;
        if (r_st == S_SMK || r_st == S_SMD) w_dnum = NB'(w_dmag);
    end

    assign w_k3 = {2'b0, r_k} + {1'b0, r_k, 1'b0};
    assign w_d2 = {1'b0, r_d, 1'b0};
    assign w_j  = JB'(w_k3) - JB'(w_d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_oload) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_seen <= '0; r_ptr <= '0;
            r_flag <= FLAG_NONE; r_ph <= '0; r_pl <= '0; r_prsv <= '0;
            r_k <= '0; r_d <= '0; r_idx <= '0; r_cnt <= '0; r_rdv <= 1'b0;
            r_first <= 1'b0; r_neg <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_h <= s_axis_tdata[PB-1:0];
                        r_l <= s_axis_tdata[2*PB-1:PB];
                        r_c <= s_axis_tdata[3*PB-1:2*PB];
                        if (s_axis_tuser) begin
                            r_seen <= '0; r_ptr <= '0;
                        end
                        r_first <= s_axis_tuser || (r_seen == '0);
                        r_st <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (r_first) r_flag <= r_iflag;
                    else if (r_h == r_l) begin
                        if (r_c >= r_ph && r_c > r_pl) r_flag <= FLAG_UP;
                        else if (r_c <= r_pl && r_c < r_ph) r_flag <= FLAG_DOWN;
                        else if (r_c < r_ph && r_c > r_pl) r_flag <= FLAG_NONE;
                    end else r_flag <= FLAG_NONE;
                    r_ptr <= (32'(r_ptr) + 1 >= WINDOW_MAX) ? '0 : r_ptr + 1'b1;
                    r_idx <= r_ptr;
                    r_hi <= r_h; r_lo <= r_l;
                    r_cnt <= ((r_seen + 1'b1) < w_winc) ? r_seen + 1'b1 : w_winc;
                    if (32'(r_seen) < WINDOW_MAX) r_seen <= r_seen + 1'b1;
                    r_rdv <= 1'b0;
                    r_st <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_rdv) begin
                        if (r_rdh > r_hi) r_hi <= r_rdh;
                        if (r_rdl < r_lo) r_lo <= r_rdl;
                    end
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_idx <= (r_idx == '0) ? AB'(WINDOW_MAX - 1) : r_idx - 1'b1;
                        r_rdv <= 1'b1;
                    end else if (r_rdv) begin
                        r_rdv <= 1'b0;
                    end else begin
                        r_cd <= w_cc - r_lo;
                        r_st <= S_RSV;
                    end
                end
                S_RSV: begin
                    if (r_hi > r_lo) r_st <= S_RDIV;
                    else begin
                        if (r_flag == FLAG_UP) r_rsv <= FULL;
                        else if (r_flag == FLAG_DOWN) r_rsv <= '0;
                        else r_rsv <= r_first ? HALF : r_prsv;
                        r_st <= S_SMK;
                    end
                end
                S_RDIV: begin
                    if (w_ddone) begin
                        r_rsv <= w_dq[VB-1:0];
                        r_st <= S_SMK;
                    end
                end
                S_SMK: begin
                    if (r_first) begin
                        r_k <= r_rsv;
                        r_d <= r_rsv;
                        r_st <= S_OUT;
                    end else begin
                        r_neg <= w_diff[VB];
                        r_st <= S_KDIV;
                    end
                end
                S_KDIV: begin
                    if (w_ddone) begin
                        r_k <= r_neg ? r_k - w_dq[VB-1:0] : r_k + w_dq[VB-1:0];
                        r_st <= S_SMD;
                    end
                end
                S_SMD: begin
                    r_neg <= w_diff[VB];
                    r_st <= S_DDIV;
                end
                S_DDIV: begin
                    if (w_ddone) begin
                        r_d <= r_neg ? r_d - w_dq[VB-1:0] : r_d + w_dq[VB-1:0];
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_oload) begin
                        r_odata <= {r_flag, w_j, r_d, r_k, r_rsv};
                        r_prsv <= r_rsv;
                        r_ph <= r_h;
                        r_pl <= r_l;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/kdj_divider.sv =====
// Shared restoring divider, one quotient bit per cycle; unsigned operands.
// Depends on nothing.
`timescale 1ns / 1ps
module kdj_divider #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] r_q;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   w_sh;
    logic                w_ge;

    assign w_sh = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};
    assign w_ge = w_sh >= {1'b0, r_den};
    assign o_quot = r_q;
    // quotient is final in the cycle that done is high
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(NUM_BITS);
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_BITS-2:0], w_ge};
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
        end
    end
endmodule

// ===== design/kdj_checker.sv =====
// Port-level checker for the stochastic KDJ oscillator, bound to the top.
// Depends on stochastic_kdj_oscillator_macros.svh and kdj_pkg.
`timescale 1ns / 1ps
`include "stochastic_kdj_oscillator_macros.svh"
module kdj_checker #(
    parameter int DW = ((4*kdj_pkg::FRACTION_BITS_DEF+40)/8)*8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [DW-1:0] m_axis_tdata
);
    `KDJ_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accept")
    `KDJ_ASSERT_NXT(a_out_holds, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `KDJ_ASSERT_NXT(a_out_stable, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while waiting")
    `KDJ_ASSERT_IMP(a_ready_known, i_clk, i_rst_n,
        1'b1, !$isunknown(s_axis_tready), "input ready unknown")
endmodule

bind stochastic_kdj_oscillator kdj_checker #(.DW(((4*FRACTION_BITS+40)/8)*8)) u_kdj_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== tb/tb_stochastic_kdj_oscillator.sv =====
// Testbench for stochastic_kdj_oscillator: streams price bars, predicts RSV/K/D/J
// and the limit flag per bar in a scoreboard class, compares every result item.
// Depends on kdj_pkg and the oscillator RTL.
`timescale 1ns / 1ps
module tb_stochastic_kdj_oscillator;
    import kdj_pkg::*;

    localparam int RING = 64;
    localparam int FRAC = 16;
    localparam longint unsigned FULL = 64'd100 << FRAC;
    localparam longint unsigned HALF = 64'd50 << FRAC;
    localparam int STALL_LIMIT = 20000;

    // rsv sits in the lowest bits
    typedef struct packed {
        logic [1:0]  limit_flag;
        logic [25:0] j_value;
        logic [22:0] d_value;
        logic [22:0] k_value;
        logic [22:0] rsv;
    } t_kdj_result;

    class kdj_scoreboard;
        int unsigned window_len = 9;
        int unsigned k_div = 3;
        int unsigned d_div = 3;
        int signed   init_flag = 0;
        logic [31:0] high_ring[RING];
        logic [31:0] low_ring[RING];
        int unsigned ptr, seen;
        logic [31:0] prev_high, prev_low;
        longint unsigned prev_rsv, k_line, d_line;
        int signed   flag;
        t_kdj_result pending_q[$];
        int unsigned errors, results;

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            int unsigned v;
            case (idx)
                CFG_WINDOW: begin
                    v = val[6:0];
                    if (v == 0) v = 1;
                    if (v > RING) v = RING;
                    window_len = v;
                end
                CFG_KSMTH: k_div = val;
                CFG_DSMTH: d_div = val;
                default: begin
                    init_flag = (val[1:0] == FLAG_UP) ? 1 :
                                (val[1:0] == FLAG_DOWN) ? -1 : 0;
                end
            endcase
        endfunction

        function longint unsigned smooth(longint unsigned prev, longint unsigned target,
                                         int unsigned m);
            longint signed diff;
            diff = longint'(target) - longint'(prev);
            diff = diff / longint'(m == 0 ? 1 : m);
            return longint'(prev) + diff;
        endfunction

        function void note_bar(bit restart, logic [31:0] h, logic [31:0] l, logic [31:0] c);
            bit first;
            int unsigned cnt, idx;
            logic [31:0] hi, lo, cc;
            longint unsigned rsv;
            longint signed jv;
            t_kdj_result r;
            if (restart) begin
                seen = 0;
                ptr = 0;
            end
            first = (seen == 0);
            if (first) flag = init_flag;
            else if (h == l) begin
                if (c >= prev_high && c > prev_low) flag = 1;
                else if (c <= prev_low && c < prev_high) flag = -1;
                else if (c < prev_high && c > prev_low) flag = 0;
            end else flag = 0;
            high_ring[ptr] = h;
            low_ring[ptr] = l;
            ptr = (ptr + 1) % RING;
            if (seen < RING) seen++;
            cnt = (seen < window_len) ? seen : window_len;
            hi = h;
            lo = l;
            idx = ptr;
            for (int i = 0; i < cnt; i++) begin
                idx = (idx == 0) ? RING - 1 : idx - 1;
                if (high_ring[idx] > hi) hi = high_ring[idx];
                if (low_ring[idx] < lo) lo = low_ring[idx];
            end
            if (hi > lo) begin
                cc = (c < lo) ? lo : (c > hi) ? hi : c;
                rsv = ((64'(cc - lo) * 100) << FRAC) / 64'(hi - lo);
            end else if (flag == 1) rsv = FULL;
            else if (flag == -1) rsv = 0;
            else rsv = first ? HALF : prev_rsv;
            if (first) begin
                k_line = rsv;
                d_line = rsv;
            end else begin
                k_line = smooth(k_line, rsv, k_div);
                d_line = smooth(d_line, k_line, d_div);
            end
            prev_rsv = rsv;
            prev_high = h;
            prev_low = l;
            jv = 3 * longint'(k_line) - 2 * longint'(d_line);
            r.rsv = rsv[22:0];
            r.k_value = k_line[22:0];
            r.d_value = d_line[22:0];
            r.j_value = jv[25:0];
            r.limit_flag = flag[1:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [103:0] data);
            t_kdj_result got, exp_r;
            got = t_kdj_result'(data[96:0]);
            results++;
            if (pending_q.size() == 0) begin
                $error("result item with no bar pending: %h", data);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.rsv !== exp_r.rsv) begin
                $error("rsv: expected %0d, got %0d", exp_r.rsv, got.rsv); errors++;
            end
            if (got.k_value !== exp_r.k_value) begin
                $error("k_value: expected %0d, got %0d", exp_r.k_value, got.k_value); errors++;
            end
            if (got.d_value !== exp_r.d_value) begin
                $error("d_value: expected %0d, got %0d", exp_r.d_value, got.d_value); errors++;
            end
            if (got.j_value !== exp_r.j_value) begin
                $error("j_value: expected %0d, got %0d",
                       $signed(exp_r.j_value), $signed(got.j_value)); errors++;
            end
            if (got.limit_flag !== exp_r.limit_flag) begin
                $error("limit_flag: expected %0d, got %0d",
                       $signed(exp_r.limit_flag), $signed(got.limit_flag)); errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [7:0]   i_cfg_data = '0;

    kdj_scoreboard sb = new();
    int unsigned send_idle = 36;
    int unsigned recv_idle = 64;
    int unsigned stall_cycles = 0;
    int unsigned bars_sent = 0;
    logic [31:0] last_high = 32'd1000, last_low = 32'd900, base_price = 32'd100000;

    stochastic_kdj_oscillator u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_bar(bit restart, logic [31:0] h, logic [31:0] l, logic [31:0] c);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= restart;
        s_axis_tdata <= {c, l, h};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_bar(restart, h, l, c);
        last_high = h;
        last_low = l;
        bars_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_bar();
        logic [31:0] h, l, c, spread;
        int unsigned kind;
        bit restart;
        restart = ($urandom_range(99) < 2);
        kind = $urandom_range(99);
        base_price = base_price + $urandom_range(200) - 100;
        spread = $urandom_range(1, 300);
        h = base_price + $urandom_range(spread);
        l = h - $urandom_range(spread);
        c = l + $urandom_range(spread);
        if (kind < 14) begin
            case ($urandom_range(4))
                0: c = last_high;
                1: c = last_low;
                2: c = last_low + (last_high - last_low) / 2;
                3: c = last_high + $urandom_range(1, 50);
                default: c = last_low - $urandom_range(1, 50);
            endcase
            h = c;
            l = c;
        end else if (kind < 20) begin
            h = $urandom;
            l = $urandom;
            c = $urandom;
        end else if (kind < 24) begin
            l = h + $urandom_range(1, 100);
        end
        send_bar(restart, h, l, c);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: flat first bar, extremes, clamping, limit moves, restart
        send_bar(0, 32'd500, 32'd500, 32'd500);
        send_bar(0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_bar(0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_bar(0, 32'd2000, 32'd1000, 32'd5000);
        send_bar(0, 32'd2000, 32'd1000, 32'd10);
        send_bar(1, 32'd3000, 32'd3000, 32'd3000);
        send_bar(0, 32'd3100, 32'd3100, 32'd3100);
        send_bar(0, 32'd3000, 32'd3000, 32'd3000);
        send_bar(0, 32'd3000, 32'd3000, 32'd3000);
        send_bar(0, 32'd3050, 32'd3000, 32'd3020);
        send_bar(0, 32'd3010, 32'd3010, 32'd3010);
        send_bar(0, 32'd100, 32'd200, 32'd150);
        send_bar(1, 32'd0, 32'd0, 32'd0);
        send_bar(0, 32'd0, 32'd0, 32'd0);
        send_bar(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(0, 32'hAAAA_5555, 32'h5555_AAAA, 32'h7FFF_FFFF);
        drain();
        write_reg(CFG_FLAG, {6'd0, FLAG_UP});
        send_bar(1, 32'd700, 32'd700, 32'd700);
        send_bar(0, 32'd700, 32'd700, 32'd700);
        drain();
        write_reg(CFG_FLAG, {6'd0, FLAG_DOWN});
        send_bar(1, 32'd700, 32'd700, 32'd700);
        drain();
        write_reg(CFG_FLAG, 8'd2);
        send_bar(1, 32'd700, 32'd700, 32'd700);

        for (int seg = 0; seg < 6; seg++) begin
            drain();
            send_idle = (seg < 2) ? 36 : (seg < 4) ? 64 : 0;
            recv_idle = (seg < 2) ? 64 : (seg < 4) ? 36 : 0;
            case (seg)
                0: begin
                    write_reg(CFG_WINDOW, 8'd1);
                    write_reg(CFG_KSMTH, 8'd1);
                    write_reg(CFG_DSMTH, 8'd1);
                    write_reg(CFG_FLAG, {6'd0, FLAG_UP});
                end
                1: begin
                    write_reg(CFG_WINDOW, 8'd64);
                    write_reg(CFG_KSMTH, 8'd255);
                    write_reg(CFG_DSMTH, 8'd255);
                    write_reg(CFG_FLAG, {6'd0, FLAG_DOWN});
                end
                2: begin
                    write_reg(CFG_WINDOW, 8'd9);
                    write_reg(CFG_KSMTH, 8'd3);
                    write_reg(CFG_DSMTH, 8'd3);
                    write_reg(CFG_FLAG, {6'd0, FLAG_NONE});
                end
                default: begin
                    write_reg(CFG_WINDOW, 8'($urandom_range(1, 64)));
                    write_reg(CFG_KSMTH, 8'($urandom_range(1, 255)));
                    write_reg(CFG_DSMTH, 8'($urandom_range(1, 255)));
                    write_reg(CFG_FLAG, 8'($urandom_range(3)));
                end
            endcase
            for (int n = 0; n < 320; n++) random_bar();
        end

        drain();
        $display("Sent %0d bars over six register settings and three flow-control mixes;",
                 bars_sent);
        $display("checked %0d result items, %0d mismatches.", sb.results, sb.errors);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/kdj_pkg.sv
design/kdj_divider.sv
design/stochastic_kdj_oscillator.sv
design/kdj_checker.sv
tb/tb_stochastic_kdj_oscillator.sv
